[hdl/tqpfp_pkg.sv]
// ----------------------------------------------------------------------------
// tqpfp_pkg
// Shared types, sizes and codes for the ordered task queue.
// ----------------------------------------------------------------------------
package tqpfp_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 16;
    localparam int ID_PORT_W = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // request opcodes
    localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_PEND   = 2'd2;
    localparam logic [1:0] OP_SET_STATE  = 2'd3;

    // entry status values
    localparam logic [1:0] TS_PENDING = 2'd0;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NO_PEND   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]           op;
        logic [ID_PORT_W-1:0] task_id;
        logic [1:0]           task_state;
    } t_request;

    typedef struct packed {
        logic [2:0]           status;
        logic [ID_PORT_W-1:0] out_id;
        logic [1:0]           out_state;
        logic                 now_empty;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture incoming request
        logic scan;   // register match / first-pending search
        logic exec;   // update queue and write result register
    } t_cmd;

    function automatic logic [ID_BITS-1:0] id_from_port(input logic [ID_PORT_W-1:0] x);
        logic [ID_BITS-1:0] r;
        r = '0;
        for (int b = 0; b < ID_BITS; b++) begin
            if (b < ID_PORT_W) begin
                r[b] = x[b];
            end
        end
        return r;
    endfunction

    function automatic logic [ID_PORT_W-1:0] id_to_port(input logic [ID_BITS-1:0] x);
        logic [ID_PORT_W-1:0] r;
        r = '0;
        for (int b = 0; b < ID_PORT_W; b++) begin
            if (b < ID_BITS) begin
                r[b] = x[b];
            end
        end
        return r;
    endfunction

endpackage

[hdl/tqpfp_ctrl.sv]
// ----------------------------------------------------------------------------
// tqpfp_ctrl
// Request sequencer: accept, scan, execute; owns the result valid flag.
// ----------------------------------------------------------------------------
module tqpfp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output tqpfp_pkg::t_cmd o_cmd
);
    import tqpfp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;
    logic   ready;
    logic   accept;
    logic   exec;

    assign out_free = !r_out_valid || !i_stall;
    // take a new request when idle, or in the same cycle the current one retires
    assign ready    = (r_state == S_IDLE) || ((r_state == S_EXEC) && out_free);
    assign accept   = i_valid && ready;
    assign exec     = (r_state == S_EXEC) && out_free;

    assign o_stall    = !ready;
    assign o_valid    = r_out_valid;
    assign o_cmd.load = accept;
    assign o_cmd.scan = (r_state == S_SCAN);
    assign o_cmd.exec = exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (exec) begin
                        r_state <= accept ? S_SCAN : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/tqpfp_dp.sv]
// ----------------------------------------------------------------------------
// tqpfp_dp
// Entry cells, parallel match with priority encode, shift/compact update.
// ----------------------------------------------------------------------------
module tqpfp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tqpfp_pkg::t_cmd     i_cmd,
    input  tqpfp_pkg::t_request i_req,
    output tqpfp_pkg::t_result  o_res
);
    import tqpfp_pkg::*;

    logic [ID_BITS-1:0] r_id [DEPTH];
    logic [1:0]         r_st [DEPTH];
    logic [CNT_W-1:0]   r_count;

    logic [ID_BITS-1:0] n_id [DEPTH];
    logic [1:0]         n_st [DEPTH];
    logic [CNT_W-1:0]   n_count;

    t_request           r_req;
    logic [ID_BITS-1:0] req_id;
    logic               r_hit;
    logic [IDX_W-1:0]   r_idx;
    logic               n_hit;
    logic [IDX_W-1:0]   n_idx;
    logic [DEPTH-1:0]   flag;
    t_result            r_res;
    t_result            n_res;
    logic               full;

    assign req_id = id_from_port(r_req.task_id);
    assign full   = (r_count == CNT_W'(DEPTH));

    // per-cell flags: pending status for pop, id match otherwise
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (r_req.op == OP_POP_PEND) begin
                flag[i] = (CNT_W'(i) < r_count) && (r_st[i] == TS_PENDING);
            end else begin
                flag[i] = (CNT_W'(i) < r_count) && (r_id[i] == req_id);
            end
        end
    end

    // priority encode, lowest index wins
    always_comb begin
        n_hit = 1'b0;
        n_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (flag[i]) begin
                n_hit = 1'b1;
                n_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_id    = r_id;
        n_st    = r_st;
        n_count = r_count;
        n_res   = '0;
        case (r_req.op)
            OP_PUSH_BACK: begin
                if (full) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_id[r_count[IDX_W-1:0]] = req_id;
                    n_st[r_count[IDX_W-1:0]] = r_req.task_state;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_res.status = ST_FULL;
                end else begin
                    for (int i = 1; i < DEPTH; i++) begin
                        n_id[i] = r_id[i-1];
                        n_st[i] = r_st[i-1];
                    end
                    n_id[0] = req_id;
                    n_st[0] = r_req.task_state;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_PEND: begin
                if (r_count == '0) begin
                    n_res.status = ST_EMPTY;
                end else if (!r_hit) begin
                    n_res.status = ST_NO_PEND;
                end else begin
                    n_res.out_id    = id_to_port(r_id[r_idx]);
                    n_res.out_state = r_st[r_idx];
                    // close the gap: cells at and above the hit pull from above
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (IDX_W'(i) >= r_idx) begin
                            n_id[i] = r_id[i+1];
                            n_st[i] = r_st[i+1];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_SET_STATE: begin
                if (r_hit) begin
                    n_st[r_idx] = r_req.task_state;
                end else begin
                    n_res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_res.status = ST_NOT_FOUND;
            end
        endcase
        n_res.now_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.scan) begin
            r_hit <= n_hit;
            r_idx <= n_idx;
        end
        if (i_cmd.exec) begin
            r_id  <= n_id;
            r_st  <= n_st;
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_res = r_res;

endmodule

[hdl/task_queue_pop_first_pending.sv]
// ----------------------------------------------------------------------------
// task_queue_pop_first_pending
// Each request passes accept, scan and exec; the result register and its
// valid are loaded at exec. The registered match and priority-encode stage
//   sits ahead of the queue update, so each request takes a scan and an exec step.
// Reset (sync, active low) empties the queue and clears the result valid.
// ----------------------------------------------------------------------------
module task_queue_pop_first_pending (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  tqpfp_pkg::t_request i_req,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output tqpfp_pkg::t_result  o_res
);
    import tqpfp_pkg::*;

    // Flow per request:
    //   accept : request captured into the datapath
    //   scan   : every cell compares in parallel (pending status for a pop,
    //            id for a set); the first hit is encoded and registered
    //   exec   : push writes/shifts, pop reads the hit cell and compacts,
    //            set rewrites the hit cell's status; result register loaded
    // A new request is taken in the exec cycle, so requests run back to back
    // while the result register is free to drain.
    // A waiting result only holds exec; a request taken while idle is still
    // scanned and then waits in exec until that result is taken.

    t_cmd cmd;

    tqpfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    tqpfp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

[verif/tb_task_queue_pop_first_pending.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_task_queue_pop_first_pending
// Self-checking bench for the ordered task queue. A short directed run hits
// the empty, no-pending, not-found, duplicate-id and full cases. Random
// request streams follow, shaped to fill, drain or churn the queue. Every
// result is checked against an in-bench queue predictor. Random idle and
// stall bursts are applied on both channels, except in the final stretch and in some random segments.
// ----------------------------------------------------------------------------
module tb_task_queue_pop_first_pending;
    import tqpfp_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 10;    // extra wait after the last expected result
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int SEGMENT_LEN  = 40;

    // entry status values not named by the package
    localparam logic [1:0] TS_RUNNING  = 2'd1;
    localparam logic [1:0] TS_EXECUTED = 2'd2;
    localparam logic [1:0] TS_DELETED  = 2'd3;

    // traffic shapes for the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_CHURN = 2;

    localparam logic [ID_PORT_W-1:0] ID_MASK =
        ID_PORT_W'((64'(1) << ID_BITS) - 64'(1));

    typedef struct packed {
        logic [ID_PORT_W-1:0] id;
        logic [1:0]           state;
    } t_entry;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_request i_req   = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_result  o_res;

    // predictor state: front of the task queue at index 0
    t_entry  task_entries[$];
    t_result pending_results[$];

    bit idle_enable   = 1'b0;
    int mismatch_count = 0;
    int result_count   = 0;
    int cycle_count    = 0;
    int stall_left     = 0;
    int op_count[4];
    int status_count[8];

    task_queue_pop_first_pending dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a missing result ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Queue predictor: applies one request to the local queue copy and
    // returns the result the block should produce for it.
    // ------------------------------------------------------------------------
    function automatic t_result apply_task_request(input t_request req);
        t_result              res;
        t_entry               hit;
        logic [ID_PORT_W-1:0] id;
        int                   k;
        res = '0;
        id  = req.task_id & ID_MASK;
        k   = -1;
        case (req.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (task_entries.size() >= DEPTH) begin
                    res.status = ST_FULL;             // rejected, queue untouched
                end else if (req.op == OP_PUSH_BACK) begin
                    task_entries.push_back(t_entry'{id, req.task_state});
                end else begin
                    task_entries.push_front(t_entry'{id, req.task_state});
                end
            end
            OP_POP_PEND: begin
                if (task_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < task_entries.size(); i++) begin
                        if (k < 0 && task_entries[i].state == TS_PENDING) k = i;
                    end
                    if (k < 0) begin
                        res.status = ST_NO_PEND;
                    end else begin
                        res.out_id    = task_entries[k].id;
                        res.out_state = task_entries[k].state;
                        task_entries.delete(k);       // gap closes, order kept
                    end
                end
            end
            default: begin
                // set status: only the match nearest the front changes
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < task_entries.size(); i++) begin
                    if (k < 0 && task_entries[i].id == id) k = i;
                end
                if (k >= 0) begin
                    hit             = task_entries[k];
                    hit.state       = req.task_state;
                    task_entries[k] = hit;
                    res.status      = ST_OK;
                end
            end
        endcase
        res.now_empty = (task_entries.size() == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Valid stays high from one request to the next unless an
    // idle burst is inserted; the payload holds while the block stalls.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_request req);
        t_result want;
        int      gap;
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap     = $urandom_range(1, 19);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req   = req;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        want = apply_task_request(req);
        pending_results.push_back(want);
        op_count[req.op]++;
        status_count[want.status]++;
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [ID_PORT_W-1:0] id,
                               input logic [1:0] state);
        t_request req;
        req.op         = op;
        req.task_id    = id;
        req.task_state = state;
        send_request(req);
    endtask

    // Receiver back-pressure: random bursts of stalled cycles.
    always @(negedge i_clk) begin
        if (!idle_enable) begin
            stall_left = 0;
            i_stall    = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;                             // burst continues
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall    = 1'b1;
            stall_left = $urandom_range(1, 19) - 1;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected status=%0d id=%h state=%0d empty=%0b,",
                     $realtime, what, want.status, want.out_id, want.out_state,
                     want.now_empty);
            $display("    got status=%0d id=%h state=%0d empty=%0b",
                     got.status, got.out_id, got.out_state, got.now_empty);
        end
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding", '0, o_res);
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status || o_res.out_id !== want.out_id ||
                    o_res.out_state !== want.out_state ||
                    o_res.now_empty !== want.now_empty) begin
                    report_mismatch("result mismatch", want, o_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random request generation
    // ------------------------------------------------------------------------
    function automatic logic [ID_PORT_W-1:0] pick_id(input bit prefer_hit);
        int roll;
        roll = $urandom_range(0, 99);
        if (prefer_hit && task_entries.size() > 0 && roll < 70)
            return task_entries[$urandom_range(0, task_entries.size() - 1)].id;
        if (roll < 80) return ID_PORT_W'($urandom_range(0, 7));   // small pool -> duplicates
        if (roll < 85) return '0;
        if (roll < 90) return '1;
        return ID_PORT_W'($urandom_range(0, 65535));
    endfunction

    function automatic t_request make_request(input int mode);
        t_request req;
        int       roll;
        int       push_pct;
        int       pop_pct;
        case (mode)
            MODE_FILL:  begin push_pct = 70; pop_pct = 15; end
            MODE_DRAIN: begin push_pct = 20; pop_pct = 55; end
            default:    begin push_pct = 40; pop_pct = 30; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            req.op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else if (roll < push_pct + pop_pct) begin
            req.op = OP_POP_PEND;
        end else begin
            req.op = OP_SET_STATE;
        end
        req.task_id    = ($urandom_range(0, 1) == 0) ? ID_PORT_W'($urandom_range(0, 65535))
                                                     : pick_id(req.op == OP_SET_STATE);
        // pushes lean pending so pops find work; sets spread across all values
        req.task_state = ($urandom_range(0, 1) == 0) ? TS_PENDING
                                                     : 2'($urandom_range(0, 3));
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_queue();
        send_fields(OP_POP_PEND, '0, TS_PENDING);       // pop on empty queue
        send_fields(OP_SET_STATE, '0, TS_RUNNING);      // set on empty -> not found
    endtask

    task automatic test_order_and_duplicates();
        send_fields(OP_PUSH_BACK,  16'h0000, TS_PENDING);
        send_fields(OP_PUSH_FRONT, 16'hFFFF, TS_DELETED);
        send_fields(OP_PUSH_BACK,  16'h0000, TS_RUNNING);
        // duplicate id: only the front-most 0x0000 changes
        send_fields(OP_SET_STATE,  16'h0000, TS_EXECUTED);
        send_fields(OP_SET_STATE,  16'h1234, TS_PENDING);   // unknown id
        send_fields(OP_POP_PEND,   16'h0000, TS_PENDING);   // nothing pending
        send_fields(OP_PUSH_BACK,  16'h5A5A, TS_PENDING);
        send_fields(OP_PUSH_FRONT, 16'hA5A5, TS_PENDING);
        send_fields(OP_POP_PEND,   16'h0000, TS_PENDING);   // takes the front
        send_fields(OP_POP_PEND,   16'h0000, TS_PENDING);   // takes the back
        send_fields(OP_SET_STATE,  16'h0000, TS_PENDING);
        send_fields(OP_POP_PEND,   16'hFFFF, TS_DELETED);   // from the middle
    endtask

    task automatic test_full_queue();
        int n;
        n = 0;
        while (task_entries.size() < DEPTH) begin
            send_fields((n % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                        ID_PORT_W'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
            n++;
        end
        send_fields(OP_PUSH_BACK,  16'hFFFF, TS_PENDING);   // rejected
        send_fields(OP_PUSH_FRONT, 16'h0000, TS_DELETED);   // rejected
        // match in the last slot
        send_fields(OP_SET_STATE, task_entries[DEPTH-1].id, TS_PENDING);
    endtask

    task automatic test_random_traffic(input int count, input bit with_idle);
        int mode;
        for (int n = 0; n < count; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                mode        = $urandom_range(MODE_FILL, MODE_CHURN);
                // some segments run without any idling even when it is allowed
                idle_enable = with_idle && ($urandom_range(0, 3) != 0);
            end
            send_request(make_request(mode));
        end
        idle_enable = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_enable = 1'b1;
        test_empty_queue();
        test_order_and_duplicates();
        test_full_queue();
        test_random_traffic(700, 1'b1);
        test_random_traffic(150, 1'b0);                // final stretch: no idling

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatch_count += pending_results.size();

        $display("Sent %0d requests: push back %0d, push front %0d, pop %0d, set %0d",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[OP_PUSH_BACK], op_count[OP_PUSH_FRONT],
                 op_count[OP_POP_PEND], op_count[OP_SET_STATE]);
        $display("Checked %0d results: ok %0d, empty %0d, no pending %0d, full %0d, %s %0d",
                 result_count, status_count[ST_OK], status_count[ST_EMPTY],
                 status_count[ST_NO_PEND], status_count[ST_FULL], "unknown id",
                 status_count[ST_NOT_FOUND]);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
